### rtl/pimf_pkg.sv
// Shared types and constants of the point-in-multipolygon filter.
`timescale 1ns / 1ps
package pimf_pkg;
   localparam int MAX_VERTICES_DEF = 256;
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int IN_COORD_W       = 32;
   localparam int HELD_W           = 9;
   localparam int REQ_DATA_W       = 72;
   localparam int RSP_DATA_W       = 16;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_TEST   = 2'd2;

   // bit positions inside a stored vertex mark
   localparam int MARK_RING = 0;
   localparam int MARK_POLY = 1;
   localparam int MARK_EXT  = 2;

   typedef enum logic [1:0] {OP_CLEAR, OP_APPEND, OP_TEST, OP_NOP} op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] marks;
   } cmd_type;

   typedef struct packed {
      logic ring_end;
      logic ext;
      logic poly_next;
   } edge_tag_type;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_CLOSE, ST_DRAIN} back_state_type;
endpackage

### rtl/pimf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pimf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/pimf_front.sv
// Request intake: decode the request kind and hold requests in a two-entry queue.
`timescale 1ns / 1ps
module pimf_front #(
   parameter int COORD_WIDTH = pimf_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pimf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                        req_tuser,
   output logic                              q_valid,
   input  logic                              q_pop,
   output pimf_pkg::cmd_type                 q_cmd,
   output logic [COORD_WIDTH-1:0]            q_x,
   output logic [COORD_WIDTH-1:0]            q_y
);
   import pimf_pkg::*;

   localparam int DEPTH = 2;

   cmd_type                cmd_ff [DEPTH];
   logic [COORD_WIDTH-1:0] x_ff [DEPTH];
   logic [COORD_WIDTH-1:0] y_ff [DEPTH];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             fill_ff, fill_in;
   cmd_type                cmd_new;
   logic                   push;

   always_comb begin
      unique case (req_tuser)
         REQ_CLEAR:  cmd_new.op = OP_CLEAR;
         REQ_APPEND: cmd_new.op = OP_APPEND;
         REQ_TEST:   cmd_new.op = OP_TEST;
         default:    cmd_new.op = OP_NOP;
      endcase
      cmd_new.marks[MARK_RING] = req_tdata[64] | req_tdata[65];
      cmd_new.marks[MARK_POLY] = req_tdata[65];
      cmd_new.marks[MARK_EXT]  = req_tdata[66];
   end

   assign req_tready = (fill_ff != 2'(DEPTH));
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_cmd      = cmd_ff[rd_ptr_ff];
   assign q_x        = x_ff[rd_ptr_ff];
   assign q_y        = y_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      fill_in   = 2'(fill_ff + {1'b0, push} - {1'b0, q_pop});
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= cmd_new;
         x_ff[wr_ptr_ff]   <= req_tdata[COORD_WIDTH-1:0];
         y_ff[wr_ptr_ff]   <= req_tdata[IN_COORD_W+COORD_WIDTH-1:IN_COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset) fill_ff <= 2'(DEPTH))
      else $error("queue overfilled");
   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("queue fill count did not advance");
endmodule

### rtl/pimf_edge.sv
// Pipelined edge-crossing test: exact cross-multiplied compare in three stages.
`timescale 1ns / 1ps
module pimf_edge #(
   parameter int COORD_WIDTH = pimf_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic signed [COORD_WIDTH-1:0] xi,
   input  logic signed [COORD_WIDTH-1:0] yi,
   input  logic signed [COORD_WIDTH-1:0] xj,
   input  logic signed [COORD_WIDTH-1:0] yj,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  pimf_pkg::edge_tag_type        in_tag,
   output logic                          out_vld,
   output logic                          out_cross,
   output pimf_pkg::edge_tag_type        out_tag,
   output logic                          busy
);
   import pimf_pkg::*;

   localparam int W = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH;

   logic signed [W-1:0]    dx_a, dy_e, dx_e, dy_p;
   logic [COORD_WIDTH-1:0] ma, mb, mc, md;
   logic                   cond;

   logic                   s1_vld_ff, s1_cond_ff, s1_pneg_ff, s1_qneg_ff;
   logic [COORD_WIDTH-1:0] s1_ma_ff, s1_mb_ff, s1_mc_ff, s1_md_ff;
   edge_tag_type           s1_tag_ff;
   logic                   s2_vld_ff, s2_cond_ff, s2_pneg_ff, s2_qneg_ff;
   logic [PW-1:0]          s2_p_ff, s2_q_ff;
   edge_tag_type           s2_tag_ff;
   logic                   s3_vld_ff, s3_cross_ff;
   edge_tag_type           s3_tag_ff;
   logic                   pn, qn, less;

   function automatic logic [COORD_WIDTH-1:0] mag(input logic signed [W-1:0] v);
      logic signed [W-1:0] n;
      n = -v;
      return v[W-1] ? n[COORD_WIDTH-1:0] : v[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      dx_a = W'(px) - W'(xi);
      dy_e = W'(yj) - W'(yi);
      dx_e = W'(xj) - W'(xi);
      dy_p = W'(py) - W'(yi);
      cond = (yi > py) != (yj > py);
      ma   = mag(dx_a);
      mb   = mag(dy_e);
      mc   = mag(dx_e);
      md   = mag(dy_p);
   end

   // Sign of the right-hand product after the edge is flipped to rise.
   always_ff @(posedge clock) begin
      s1_cond_ff <= cond;
      s1_pneg_ff <= dx_a[W-1];
      s1_qneg_ff <= dx_e[W-1] ^ dy_p[W-1] ^ dy_e[W-1];
      s1_ma_ff   <= ma;
      s1_mb_ff   <= mb;
      s1_mc_ff   <= mc;
      s1_md_ff   <= md;
      s1_tag_ff  <= in_tag;
      s2_cond_ff <= s1_cond_ff;
      s2_pneg_ff <= s1_pneg_ff;
      s2_qneg_ff <= s1_qneg_ff;
      s2_p_ff    <= s1_ma_ff * s1_mb_ff;
      s2_q_ff    <= s1_mc_ff * s1_md_ff;
      s2_tag_ff  <= s1_tag_ff;
      s3_cross_ff <= s2_cond_ff & less;
      s3_tag_ff  <= s2_tag_ff;
   end

   always_comb begin
      pn = (s2_p_ff != '0) & s2_pneg_ff;
      qn = (s2_q_ff != '0) & s2_qneg_ff;
      if (pn != qn) begin
         less = pn;
      end else if (pn) begin
         less = s2_p_ff > s2_q_ff;
      end else begin
         less = s2_p_ff < s2_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   assign out_vld   = s3_vld_ff;
   assign out_cross = s3_cross_ff;
   assign out_tag   = s3_tag_ff;
   assign busy      = s1_vld_ff | s2_vld_ff | s3_vld_ff;
endmodule

### rtl/pimf_back.sv
// Request execution: vertex table, ring walker, ring/polygon combiner, result register.
`timescale 1ns / 1ps
module pimf_back #(
   parameter int MAX_VERTICES = pimf_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = pimf_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  pimf_pkg::cmd_type               q_cmd,
   input  logic [COORD_WIDTH-1:0]          q_x,
   input  logic [COORD_WIDTH-1:0]          q_y,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pimf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pimf_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CW = COORD_WIDTH;
   localparam int VW = 2 * CW + 3;

   back_state_type state_ff, state_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]  rd_addr_ff, rd_addr_in;
   logic           issue_done_ff, issue_done_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic           par_ff, par_in, inpoly_ff, inpoly_in;
   logic           blocked_ff, blocked_in, keep_ff, keep_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_keep_ff, rsp_status_ff;
   logic [HELD_W-1:0] rsp_held_ff;

   logic [CW-1:0]  px_ff, py_ff, first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic           ring_ext_ff;
   logic           pt_load, first_load, prev_load;

   logic           rsp_load, rsp_keep_n, rsp_status_n;
   logic [NW-1:0]  rsp_held_n;

   logic           wr_en;
   logic [VW-1:0]  wr_data, rd_data;
   logic [CW-1:0]  v_x, v_y;
   logic [2:0]     v_marks;
   logic [AW-1:0]  last_idx;
   logic           v_begin;

   logic           e_vld, o_vld, o_cross, e_busy;
   logic [CW-1:0]  e_xi, e_yi, e_xj, e_yj;
   edge_tag_type   e_tag, o_tag;
   logic           ring_in, ip, bl;

   assign v_x      = rd_data[CW-1:0];
   assign v_y      = rd_data[2*CW-1:CW];
   assign v_marks  = rd_data[VW-1:2*CW];
   assign last_idx = AW'(cnt_ff - NW'(1));
   assign v_begin  = (rd_idx_ff == '0) | v_marks[MARK_RING];
   assign wr_data  = {q_cmd.marks, q_y, q_x};

   pimf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cnt_ff)),
      .wr_data (wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   pimf_edge #(.COORD_WIDTH(CW)) u_edge (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (e_vld),
      .xi        (e_xi),
      .yi        (e_yi),
      .xj        (e_xj),
      .yj        (e_yj),
      .px        (px_ff),
      .py        (py_ff),
      .in_tag    (e_tag),
      .out_vld   (o_vld),
      .out_cross (o_cross),
      .out_tag   (o_tag),
      .busy      (e_busy)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_addr_in    = rd_addr_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      par_in        = par_ff;
      inpoly_in     = inpoly_ff;
      blocked_in    = blocked_ff;
      keep_in       = keep_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      pt_load       = 1'b0;
      first_load    = 1'b0;
      prev_load     = 1'b0;
      rsp_load      = 1'b0;
      rsp_keep_n    = 1'b0;
      rsp_status_n  = 1'b0;
      rsp_held_n    = cnt_ff;
      e_vld         = 1'b0;
      e_xi          = first_x_ff;
      e_yi          = first_y_ff;
      e_xj          = prev_x_ff;
      e_yj          = prev_y_ff;
      e_tag         = '{ring_end: 1'b1, ext: ring_ext_ff, poly_next: 1'b0};
      ring_in       = 1'b0;
      ip            = inpoly_ff;
      bl            = blocked_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_CLEAR: begin
                     cnt_in     = '0;
                     rsp_held_n = '0;
                     rsp_load   = 1'b1;
                  end
                  OP_APPEND: begin
                     if (cnt_ff == NW'(MAX_VERTICES)) begin
                        rsp_status_n = 1'b1;
                     end else begin
                        wr_en      = 1'b1;
                        cnt_in     = cnt_ff + NW'(1);
                        rsp_held_n = cnt_in;
                     end
                     rsp_load = 1'b1;
                  end
                  OP_TEST: begin
                     if (cnt_ff == '0) begin
                        rsp_keep_n = 1'b1;
                        rsp_load   = 1'b1;
                     end else begin
                        pt_load       = 1'b1;
                        rd_addr_in    = '0;
                        issue_done_in = 1'b0;
                        par_in        = 1'b0;
                        inpoly_in     = 1'b0;
                        blocked_in    = 1'b0;
                        keep_in       = 1'b0;
                        state_in      = ST_WALK;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_WALK: begin
            // issue one table read per cycle
            if (!issue_done_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_addr_ff;
               if (rd_addr_ff == last_idx) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_addr_in = rd_addr_ff + AW'(1);
               end
            end
            if (rd_vld_ff) begin
               prev_load = 1'b1;
               if (v_begin) begin
                  // close the ring that just ended
                  first_load      = 1'b1;
                  e_vld           = (rd_idx_ff != '0);
                  e_tag.poly_next = v_marks[MARK_POLY];
               end else begin
                  e_vld = 1'b1;
                  e_xi  = v_x;
                  e_yi  = v_y;
                  e_tag = '{ring_end: 1'b0, ext: 1'b0, poly_next: 1'b0};
               end
               if (rd_idx_ff == last_idx) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            e_vld    = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!e_busy) begin
               rsp_keep_n = keep_ff | inpoly_ff;
               rsp_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // fold edge crossings into ring and polygon verdicts
      if (o_vld) begin
         ring_in = par_ff ^ o_cross;
         if (!o_tag.ring_end) begin
            par_in = ring_in;
         end else begin
            par_in = 1'b0;
            if (!bl && ring_in) begin
               if (o_tag.ext) begin
                  ip = 1'b1;
               end else begin
                  ip = 1'b0;
                  bl = 1'b1;
               end
            end
            if (o_tag.poly_next) begin
               keep_in = keep_ff | ip;
               ip      = 1'b0;
               bl      = 1'b0;
            end
            inpoly_in  = ip;
            blocked_in = bl;
         end
      end

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (pt_load) begin
         px_ff <= q_x;
         py_ff <= q_y;
      end
      if (first_load) begin
         first_x_ff  <= v_x;
         first_y_ff  <= v_y;
         ring_ext_ff <= v_marks[MARK_EXT];
      end
      if (prev_load) begin
         prev_x_ff <= v_x;
         prev_y_ff <= v_y;
      end
      if (rsp_load) begin
         rsp_keep_ff   <= rsp_keep_n;
         rsp_status_ff <= rsp_status_n;
         rsp_held_ff   <= HELD_W'(rsp_held_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rd_addr_ff    <= '0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_idx_ff     <= '0;
         par_ff        <= 1'b0;
         inpoly_ff     <= 1'b0;
         blocked_ff    <= 1'b0;
         keep_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_addr_ff    <= rd_addr_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         rd_idx_ff     <= rd_idx_in;
         par_ff        <= par_in;
         inpoly_ff     <= inpoly_in;
         blocked_ff    <= blocked_in;
         keep_ff       <= keep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_held_ff, rsp_status_ff, rsp_keep_ff});

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MAX_VERTICES))
      else $error("vertex count beyond table size");
   a_edge_in_walk: assert property (@(posedge clock) disable iff (reset)
      e_vld |-> (state_ff == ST_WALK || state_ff == ST_CLOSE))
      else $error("edge issued outside a point test");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff)
      else $error("result register overwritten");
   a_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !e_busy)
      else $error("edge pipe busy while idle");
endmodule

### rtl/point_in_multipolygon_filter.sv
// Top level of the point-in-multipolygon filter.
`timescale 1ns / 1ps
// Point-in-multipolygon filter.
// Request channel (req_*): tuser carries the kind (clear table, append vertex,
// test point); tdata carries the vertex or point and the ring/polygon marks.
// Each request yields exactly one response on rsp_*: keep flag, table-full
// flag and the number of vertices held afterwards.
// Requests enter a two-entry queue, so the channel keeps taking requests while
// a response waits. Clear, append and unknown requests are executed from the
// queue straight into the result register; none starts while a response is held.
// A point test loads the point, then the ring walker reads one vertex per
// cycle from the table port and feeds one edge per cycle into a three-stage
// multiply/compare pipe; the last ring is then closed and the pipe drained.
// Reset empties the queue and the table count; table contents are not cleared.
// When rsp_tready is low the response holds, no further request is executed
// and the queue fills, then req_tready drops.
module point_in_multipolygon_filter #(
   parameter int MAX_VERTICES = pimf_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = pimf_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // coord_x[31:0], coord_y[63:32], begins_ring[64], begins_polygon[65],
   // ring_is_exterior[66], zero fill to 72
   input  logic [pimf_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // keep_point[0], status[1], vertices_held[10:2], zero fill to 16
   output logic [pimf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pimf_pkg::*;

   logic                   q_valid, q_pop;
   cmd_type                q_cmd;
   logic [COORD_WIDTH-1:0] q_x, q_y;

   pimf_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .q_x        (q_x),
      .q_y        (q_y)
   );

   pimf_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .q_x        (q_x),
      .q_y        (q_y),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

### test/point_in_multipolygon_filter_test.sv
// Self-checking testbench for the point-in-multipolygon filter.
`timescale 1ns / 1ps
module point_in_multipolygon_filter_test;
   import pimf_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic       keep;
      logic       full;
      logic [8:0] held;
   } verdict_type;

   // Expected-response tracker with its own copy of the vertex table.
   class verdict_board;
      logic signed [31:0] vx[MAX_VERTICES_DEF];
      logic signed [31:0] vy[MAX_VERTICES_DEF];
      logic [2:0]         vm[MAX_VERTICES_DEF];
      int                 count;
      verdict_type        pending[$];
      int                 errors;

      function void clear_all();
         count = 0;
         pending.delete();
         errors = 0;
      endfunction

      // a*b < c*d exactly; factors fit in 34 bits signed
      function bit prod_lt(longint a, longint b, longint c, longint d);
         logic signed [71:0] p, q;
         p = 72'(a) * 72'(b);
         q = 72'(c) * 72'(d);
         return p < q;
      endfunction

      function bit ring_has(int s, int e, longint x, longint y);
         bit in;
         int j;
         longint dy, py;
         in = 0;
         j = e - 1;
         for (int i = s; i < e; i++) begin
            if ((vy[i] > y) != (vy[j] > y)) begin
               dy = longint'(vy[j]) - vy[i];
               py = y - vy[i];
               if (dy < 0) begin
                  dy = -dy;
                  py = -py;
               end
               if (prod_lt(x - vx[i], dy, longint'(vx[j]) - vx[i], py)) in = !in;
            end
            j = i;
         end
         return in;
      endfunction

      function bit point_kept(longint x, longint y);
         bit keep, inpoly, blocked;
         int s, e;
         keep = 0; inpoly = 0; blocked = 0; s = 0;
         if (count == 0) return 1;
         while (s < count) begin
            e = s + 1;
            while (e < count && vm[e][MARK_RING] == 0 && vm[e][MARK_POLY] == 0) e++;
            if (s == 0 || vm[s][MARK_POLY]) begin
               keep = keep || inpoly;
               inpoly = 0;
               blocked = 0;
            end
            if (!blocked && ring_has(s, e, x, y)) begin
               if (vm[s][MARK_EXT]) inpoly = 1;
               else begin
                  inpoly = 0;
                  blocked = 1;
               end
            end
            s = e;
         end
         return keep || inpoly;
      endfunction

      function void note_request(logic [1:0] kind, logic [71:0] d);
         verdict_type v;
         logic signed [31:0] x, y;
         x = d[31:0];
         y = d[63:32];
         v = '0;
         case (kind)
            REQ_CLEAR: count = 0;
            REQ_APPEND: begin
               if (count >= MAX_VERTICES_DEF) v.full = 1;
               else begin
                  vx[count] = x;
                  vy[count] = y;
                  vm[count] = {d[66], d[65], d[64] | d[65]};
                  count++;
               end
            end
            REQ_TEST: v.keep = point_kept(x, y);
            default: ;
         endcase
         v.held = 9'(count);
         pending.push_back(v);
      endfunction

      function void check_response(logic [15:0] d);
         verdict_type w;
         if (pending.size() == 0) begin
            $error("unexpected response %h", d);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (d[0] !== w.keep) begin
            $error("keep_point expected %0d actual %0d", w.keep, d[0]);
            errors++;
         end
         if (d[1] !== w.full) begin
            $error("status expected %0d actual %0d", w.full, d[1]);
            errors++;
         end
         if (d[10:2] !== w.held) begin
            $error("vertices_held expected %0d actual %0d", w.held, d[10:2]);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic [15:0] rsp_tdata;
   verdict_board board;
   bit          no_idle, hold_off;
   int          cycles;

   point_in_multipolygon_filter DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off) rsp_tready <= 0;
      else rsp_tready <= no_idle || ($urandom_range(99) >= 13);
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return 32'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   // Offer one request and wait until it is taken.
   task automatic send(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                       logic [2:0] marks);
      if (!no_idle)
         while ($urandom_range(99) < 13) begin
            req_tvalid <= 0;
            @(posedge clock);
         end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, marks, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, {5'b0, marks, y, x});
   endtask

   // Drop valid and wait until every outstanding response has arrived, or give up at a cycle limit.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      cycles = 1;
      while (board.pending.size() != 0 && cycles < 200000) begin
         @(posedge clock);
         cycles++;
      end
   endtask

   task automatic square_poly(int c, int h, bit ext, bit newpoly);
      send(REQ_APPEND, c - h, c - h, {ext, newpoly, 1'b1});
      send(REQ_APPEND, c + h, c - h, 3'b000);
      send(REQ_APPEND, c + h, c + h, 3'b000);
      send(REQ_APPEND, c - h, c + h, 3'b000);
   endtask

   initial begin
      board = new();
      board.clear_all();
      reset = 1; req_tvalid = 0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 0; no_idle = 0; hold_off = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, unknown kind, extremes, short ring, holes
      send(REQ_TEST, 32'h8000_0000, 32'h7fff_ffff, 3'b000);
      send(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 3'b111);
      send(REQ_APPEND, 32'h8000_0000, 32'h8000_0000, 3'b000);
      send(REQ_APPEND, 32'h7fff_ffff, 32'h8000_0000, 3'b000);
      send(REQ_APPEND, 32'h0, 32'h7fff_ffff, 3'b000);
      send(REQ_TEST, 0, 0, 3'b000);
      send(REQ_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 3'b000);
      send(REQ_APPEND, 50, 50, 3'b111);
      send(REQ_APPEND, 60, 60, 3'b000);
      send(REQ_TEST, 55, 55, 3'b000);
      send(REQ_CLEAR, 0, 0, 3'b000);
      square_poly(0, 20, 1, 1);
      square_poly(0, 5, 0, 0);
      square_poly(0, 2, 1, 0);
      send(REQ_TEST, 0, 0, 3'b000);
      send(REQ_TEST, 10, 10, 3'b000);
      send(REQ_TEST, 30, 0, 3'b000);
      drain();

      // fill to full, then overflow
      send(REQ_CLEAR, 0, 0, 3'b000);
      no_idle = 1;
      for (int i = 0; i < 258; i++)
         send(REQ_APPEND, pick_coord(), pick_coord(), 3'($urandom));
      no_idle = 0;
      repeat (3) send(REQ_TEST, pick_coord(), pick_coord(), 3'b000);

      // receiver holds off while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send(REQ_TEST, pick_coord(), pick_coord(), 3'b000);
      join
      drain();

      // random shapes with small tables
      for (int n = 0; n < 1100; ) begin
         send(REQ_CLEAR, 0, 0, 3'b000);
         n++;
         for (int p = $urandom_range(1, 3); p > 0; p--) begin
            square_poly($signed($urandom_range(100)) - 50, $urandom_range(1, 40),
                        1, 1);
            if ($urandom_range(1)) square_poly($signed($urandom_range(60)) - 30,
                                               $urandom_range(1, 20), 0, 0);
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(1, 4))
                  send(REQ_APPEND, pick_coord(), pick_coord(), 3'($urandom));
            n += 8;
         end
         no_idle = ($urandom_range(9) == 0);
         repeat ($urandom_range(4, 12)) begin
            send($urandom_range(19) == 0 ? REQ_UNUSED : REQ_TEST, pick_coord(),
                 pick_coord(), 3'($urandom));
            n++;
         end
         no_idle = 0;
         if ($urandom_range(15) == 0) drain();
      end

      drain();
      repeat (50) @(posedge clock);
      if (board.pending.size() != 0) begin
         $error("responses missing: %0d", board.pending.size());
         board.errors++;
      end
      if (board.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
